// ===== design/address_range_symbol_lookup_macros.svh =====
// Assertion macros for the address range symbol lookup block.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ADDRESS_RANGE_SYMBOL_LOOKUP_MACROS_SVH
`define ADDRESS_RANGE_SYMBOL_LOOKUP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ARSL_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ARSL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ARSL_ASSERT_IMPL(name, ante, cons, msg)
`define ARSL_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== design/arsl_pkg.sv =====
// Shared types and constants of the address range symbol lookup block.
// Depends on nothing.
`default_nettype none
package arsl_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int ADDR_W = 64;
	localparam int LEN_W = 32;
	localparam int HND_W = 16;
	localparam int FUNC_W = 2;
	localparam int STATUS_W = 3;
	localparam logic [LEN_W-1:0] WINDOW_RESET = 32'h0000_1000;

	typedef enum logic [FUNC_W-1:0] {
		FN_RESOLVE = 2'd0,
		FN_INSERT  = 2'd1,
		FN_REMOVE  = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_EXACT    = 3'd0,
		ST_OFFSET   = 3'd1,
		ST_MISS     = 3'd2,
		ST_INSERTED = 3'd3,
		ST_REPLACED = 3'd4,
		ST_REMOVED  = 3'd5,
		ST_ABSENT   = 3'd6,
		ST_FULL     = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_FIND_CMP,
		S_EXEC,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             le;
		logic             eq;
		logic             hit;
		logic [LEN_W-1:0] delta;
	} cmp_res_t;

endpackage
`default_nettype wire

// ===== design/arsl_mem.sv =====
// Symbol table storage: one write port, one read port with registered data.
// Depends on arsl_pkg.
`default_nettype none
module arsl_mem import arsl_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int WIDTH = ADDR_W + LEN_W + HANDLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/arsl_cmp.sv =====
// Shared compare unit: order test, exact match, distance and range check.
// Depends on arsl_pkg.
`default_nettype none
module arsl_cmp import arsl_pkg::*; (
	input  wire logic [ADDR_W-1:0] key,
	input  wire logic [ADDR_W-1:0] start,
	input  wire logic [LEN_W-1:0]  length,
	input  wire logic [LEN_W-1:0]  window,
	output cmp_res_t               res
);

	logic [ADDR_W-1:0] delta;
	logic              high_zero;
	logic [LEN_W-1:0]  limit;

	always_comb begin
		delta     = key - start;
		high_zero = (delta[ADDR_W-1:LEN_W] == '0);
		limit     = (length != '0) ? length : window;
		res.le    = (start <= key);
		res.eq    = (start == key);
		res.hit   = res.eq || (high_zero && (delta[LEN_W-1:0] < limit));
		res.delta = delta[LEN_W-1:0];
	end

endmodule
`default_nettype wire

// ===== design/address_range_symbol_lookup.sv =====
// Channel   Signals                                          Dir  Handshake
// input     func, address, symbol_length, symbol_handle      in   in_valid / in_stall
// result    status, found_handle/start/length, offset        out  out_valid / out_stall
// config    cfg_data (unsized_window)                        in   cfg_valid / cfg_ready
//
// One item at a time. The binary search over n entries makes at most ceil(log2(n+1)) probes,
// each a memory read, then a compare; then come the last read and compare where needed,
// execute and result, and the block returns to idle before it takes the next item.
// Insert and remove add a final move step plus a read and a write per shifted entry.
// Reset clears the entry count but not the memory; no clearing pass runs over it.
// A result held by out_stall keeps the next item from finishing, not from entering.
// Depends on arsl_pkg, arsl_mem, arsl_cmp and the macros header.
`default_nettype none
`include "address_range_symbol_lookup_macros.svh"
module address_range_symbol_lookup import arsl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [ADDR_W-1:0]   address,
	input  wire logic [LEN_W-1:0]    symbol_length,
	input  wire logic [HND_W-1:0]    symbol_handle,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [HND_W-1:0]         found_handle,
	output logic [ADDR_W-1:0]        found_start,
	output logic [LEN_W-1:0]         found_length,
	output logic [LEN_W-1:0]         offset,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [LEN_W-1:0]    cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = ADDR_W + LEN_W + HANDLE_BITS;
	localparam int HN = (HANDLE_BITS < HND_W) ? HANDLE_BITS : HND_W;

	state_t                 state_q, state_d;
	func_t                  func_q;
	logic [ADDR_W-1:0]      key_q;
	logic [LEN_W-1:0]       len_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [LEN_W-1:0]       window_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          lo_q, hi_q, mid_q, j_q;
	logic                   fnd_q, eq_q, hit_q;
	logic [LEN_W-1:0]       delta_q;
	logic [ADDR_W-1:0]      ent_start_q;
	logic [LEN_W-1:0]       ent_len_q;
	logic [HANDLE_BITS-1:0] ent_hnd_q;
	status_t                res_status_q;
	logic [HND_W-1:0]       res_hnd_q;
	logic [ADDR_W-1:0]      res_start_q;
	logic [LEN_W-1:0]       res_len_q, res_off_q;
	logic                   out_valid_q;
	status_t                status_q;
	logic [HND_W-1:0]       found_handle_q;
	logic [ADDR_W-1:0]      found_start_q;
	logic [LEN_W-1:0]       found_length_q, offset_q;

	logic [CW:0]            mid_sum;
	logic [CW-1:0]          mid, km1, jm1, jp1;
	logic [HANDLE_BITS-1:0] hnd_in;
	logic [HND_W-1:0]       hnd_out;
	logic                   out_free;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [EW-1:0]          mem_wdata, mem_rdata;
	logic [ADDR_W-1:0]      rd_start;
	logic [LEN_W-1:0]       rd_len;
	logic [HANDLE_BITS-1:0] rd_hnd;
	cmp_res_t               cmp;

	arsl_mem #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_start = mem_rdata[EW-1 -: ADDR_W];
	assign rd_len   = mem_rdata[HANDLE_BITS+LEN_W-1 -: LEN_W];
	assign rd_hnd   = mem_rdata[HANDLE_BITS-1:0];

	arsl_cmp u_cmp (
		.key    (key_q),
		.start  (rd_start),
		.length (rd_len),
		.window (window_q),
		.res    (cmp)
	);

	always_comb begin
		hnd_in  = '0;
		hnd_out = '0;
		for (int i = 0; i < HN; i++) begin
			hnd_in[i]  = symbol_handle[i];
			hnd_out[i] = ent_hnd_q[i];
		end
	end

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CW:1];
	assign km1      = lo_q - CW'(1);
	assign jm1      = j_q - CW'(1);
	assign jp1      = j_q + CW'(1);
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall     = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_handle = found_handle_q;
	assign found_start  = found_start_q;
	assign found_length = found_length_q;
	assign offset       = offset_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (lo_q < hi_q) begin
					mem_raddr = mid[AW-1:0];
					state_d   = S_SRCH_CMP;
				end else if (lo_q != '0) begin
					mem_raddr = km1[AW-1:0];
					state_d   = S_FIND_CMP;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_SRCH_CMP: state_d = S_SRCH_RD;
			S_FIND_CMP: state_d = S_EXEC;
			S_EXEC: begin
				unique case (func_q)
					FN_INSERT: begin
						if (fnd_q && eq_q) begin
							mem_we    = 1'b1;
							mem_waddr = km1[AW-1:0];
							mem_wdata = {ent_start_q, len_q, hnd_q};
							state_d   = S_DONE;
						end else if (count_q == CW'(TABLE_DEPTH)) begin
							state_d = S_DONE;
						end else begin
							state_d = S_MOVE_RD;
						end
					end
					FN_REMOVE: state_d = (fnd_q && eq_q) ? S_MOVE_RD : S_DONE;
					FN_RESOLVE: state_d = S_DONE;
					default: state_d = S_DONE;
				endcase
			end
			S_MOVE_RD: begin
				if (func_q == FN_INSERT) begin
					if (j_q == lo_q) begin
						mem_we    = 1'b1;
						mem_waddr = lo_q[AW-1:0];
						mem_wdata = {key_q, len_q, hnd_q};
						state_d   = S_DONE;
					end else begin
						mem_raddr = jm1[AW-1:0];
						state_d   = S_MOVE_WR;
					end
				end else if (jp1 == count_q) begin
					state_d = S_DONE;
				end else begin
					mem_raddr = jp1[AW-1:0];
					state_d   = S_MOVE_WR;
				end
			end
			S_MOVE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = j_q[AW-1:0];
				mem_wdata = mem_rdata;
				state_d   = S_MOVE_RD;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			window_q    <= WINDOW_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (state_q == S_MOVE_RD) begin
				if (func_q == FN_INSERT && j_q == lo_q) begin
					count_q <= count_q + CW'(1);
				end else if (func_q != FN_INSERT && jp1 == count_q) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					func_q <= func_t'(func);
					key_q  <= address;
					len_q  <= symbol_length;
					hnd_q  <= hnd_in;
					lo_q   <= '0;
					hi_q   <= count_q;
					fnd_q  <= 1'b0;
				end
			end
			S_SRCH_RD: mid_q <= mid;
			S_SRCH_CMP: begin
				if (cmp.le) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			S_FIND_CMP: begin
				fnd_q       <= 1'b1;
				eq_q        <= cmp.eq;
				hit_q       <= cmp.hit;
				delta_q     <= cmp.delta;
				ent_start_q <= rd_start;
				ent_len_q   <= rd_len;
				ent_hnd_q   <= rd_hnd;
			end
			S_EXEC: begin
				res_status_q <= ST_MISS;
				res_hnd_q    <= '0;
				res_start_q  <= '0;
				res_len_q    <= '0;
				res_off_q    <= '0;
				unique case (func_q)
					FN_RESOLVE: begin
						if (fnd_q && hit_q) begin
							res_status_q <= eq_q ? ST_EXACT : ST_OFFSET;
							res_hnd_q    <= hnd_out;
							res_start_q  <= ent_start_q;
							res_len_q    <= ent_len_q;
							res_off_q    <= delta_q;
						end
					end
					FN_INSERT: begin
						if (fnd_q && eq_q) begin
							res_status_q <= ST_REPLACED;
						end else if (count_q == CW'(TABLE_DEPTH)) begin
							res_status_q <= ST_FULL;
						end else begin
							j_q <= count_q;
						end
					end
					FN_REMOVE: begin
						if (fnd_q && eq_q) begin
							j_q <= km1;
						end else begin
							res_status_q <= ST_ABSENT;
						end
					end
					default: res_status_q <= ST_MISS;
				endcase
			end
			S_MOVE_RD: begin
				if (func_q == FN_INSERT && j_q == lo_q) begin
					res_status_q <= ST_INSERTED;
				end else if (func_q != FN_INSERT && jp1 == count_q) begin
					res_status_q <= ST_REMOVED;
				end
			end
			S_MOVE_WR: j_q <= (func_q == FN_INSERT) ? jm1 : jp1;
			S_DONE: begin
				if (out_free) begin
					status_q       <= res_status_q;
					found_handle_q <= res_hnd_q;
					found_start_q  <= res_start_q;
					found_length_q <= res_len_q;
					offset_q       <= res_off_q;
				end
			end
			default: ;
		endcase
	end

	`ARSL_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "entry count beyond depth")
	`ARSL_ASSERT_NEXT(a_accept_search, in_valid && !in_stall, state_q == S_SRCH_RD, "item not searched")
	`ARSL_ASSERT_NEXT(a_count_hold, state_q != S_MOVE_RD, $stable(count_q), "count changed outside move")
	`ARSL_ASSERT_IMPL(a_search_window, state_q == S_SRCH_RD || state_q == S_SRCH_CMP, lo_q <= hi_q && hi_q <= count_q, "search bounds out of order")

endmodule
`default_nettype wire

// ===== verif/address_range_symbol_lookup_test.sv =====
// Self-checking testbench for address_range_symbol_lookup: random and directed symbol
// table traffic, with results checked against an in-bench model of the sorted table.
// Depends on arsl_pkg and the address_range_symbol_lookup RTL.
module address_range_symbol_lookup_test;
	import arsl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int POOL_SIZE = 40;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam logic [HND_W-1:0] HANDLE_MASK =
		(HANDLE_BITS_DEF >= HND_W) ? '1 : HND_W'((1 << HANDLE_BITS_DEF) - 1);
	localparam logic [ADDR_W-1:0] FILL_BASE = 64'h4000_0000_0000_0000;
	localparam logic [ADDR_W-1:0] FILL_STEP = 64'h40;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  length;
		logic [HND_W-1:0]  handle;
	} symbol_op_t;

	typedef struct packed {
		status_t           status;
		logic [HND_W-1:0]  handle;
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  offset;
	} lookup_reply_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func = '0;
	logic [ADDR_W-1:0]   address = '0;
	logic [LEN_W-1:0]    symbol_length = '0;
	logic [HND_W-1:0]    symbol_handle = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [HND_W-1:0]    found_handle;
	logic [ADDR_W-1:0]   found_start;
	logic [LEN_W-1:0]    found_length;
	logic [LEN_W-1:0]    offset;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [LEN_W-1:0]    cfg_data = '0;

	symbol_op_t    pending_ops[$];
	lookup_reply_t awaited_replies[$];
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	int            mismatch_count = 0;
	int            cycle_count = 0;

	logic [ADDR_W-1:0] row_start[DEPTH];
	logic [LEN_W-1:0]  row_length[DEPTH];
	logic [HND_W-1:0]  row_handle[DEPTH];
	int                row_count = 0;
	logic [LEN_W-1:0]  window_setting = WINDOW_RESET;

	logic [ADDR_W-1:0] pool_addr[POOL_SIZE];
	logic [LEN_W-1:0]  pool_len[POOL_SIZE];

	address_range_symbol_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.address(address),
		.symbol_length(symbol_length),
		.symbol_handle(symbol_handle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_handle(found_handle),
		.found_start(found_start),
		.found_length(found_length),
		.offset(offset),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic lookup_reply_t apply_symbol_op(symbol_op_t op);
		lookup_reply_t     r;
		int                k;
		int                j;
		logic              exact;
		logic              hit;
		logic [ADDR_W-1:0] delta;
		r = '0;
		r.status = ST_MISS;
		k = 0;
		while (k < row_count && row_start[k] <= op.address)
			k++;
		exact = (k > 0) && (row_start[k-1] == op.address);
		case (op.func)
			FN_RESOLVE: begin
				if (k > 0) begin
					delta = op.address - row_start[k-1];
					if (exact)
						hit = 1'b1;
					else if (row_length[k-1] != '0)
						hit = delta < {32'h0, row_length[k-1]};
					else
						hit = delta < {32'h0, window_setting};
					if (hit) begin
						r.status = exact ? ST_EXACT : ST_OFFSET;
						r.handle = row_handle[k-1];
						r.start = row_start[k-1];
						r.length = row_length[k-1];
						r.offset = delta[LEN_W-1:0];
					end
				end
			end
			FN_INSERT: begin
				if (exact) begin
					row_length[k-1] = op.length;
					row_handle[k-1] = op.handle & HANDLE_MASK;
					r.status = ST_REPLACED;
				end else if (row_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (j = row_count; j > k; j--) begin
						row_start[j] = row_start[j-1];
						row_length[j] = row_length[j-1];
						row_handle[j] = row_handle[j-1];
					end
					row_start[k] = op.address;
					row_length[k] = op.length;
					row_handle[k] = op.handle & HANDLE_MASK;
					row_count++;
					r.status = ST_INSERTED;
				end
			end
			FN_REMOVE: begin
				if (exact) begin
					for (j = k - 1; j + 1 < row_count; j++) begin
						row_start[j] = row_start[j+1];
						row_length[j] = row_length[j+1];
						row_handle[j] = row_handle[j+1];
					end
					row_count--;
					r.status = ST_REMOVED;
				end else begin
					r.status = ST_ABSENT;
				end
			end
			default: r.status = ST_MISS;
		endcase
		return r;
	endfunction

	// driver: hold the item until accepted, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				awaited_replies.push_back(apply_symbol_op(
					'{func, address, symbol_length, symbol_handle}));
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					symbol_op_t op;
					op = pending_ops.pop_front();
					in_valid <= 1'b1;
					func <= op.func;
					address <= op.address;
					symbol_length <= op.length;
					symbol_handle <= op.handle;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				lookup_reply_t got;
				lookup_reply_t want;
				got = '{status_t'(status), found_handle, found_start, found_length, offset};
				if (awaited_replies.size() == 0) begin
					$display("%0t: result with none expected: status %0d handle %h start %h",
						$time, status, found_handle, found_start);
					mismatch_count++;
				end else begin
					want = awaited_replies.pop_front();
					if (got !== want) begin
						$display("%0t: expected status %0d handle %h start %h length %h offset %h",
							$time, want.status, want.handle, want.start, want.length,
							want.offset);
						$display("%0t: actual   status %0d handle %h start %h length %h offset %h",
							$time, got.status, got.handle, got.start, got.length, got.offset);
						mismatch_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_op(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
		input logic [LEN_W-1:0] l, input logic [HND_W-1:0] h);
		pending_ops.push_back('{f, a, l, h});
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_ops.size() > 0 || in_valid || awaited_replies.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic start_phase(input logic [LEN_W-1:0] window, input int idle, input int stall);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= window;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		window_setting = window;
		send_idle_pct = idle;
		stall_pct = stall;
		@(negedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] pick_delta(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] l;
		l = {32'h0, len};
		case ($urandom_range(0, 8))
			0: return '0;
			1: return 64'd1;
			2: return l - 64'd1;
			3: return l;
			4: return l + 64'd1;
			5: return 64'($urandom_range(0, len));
			6: return {32'h0, window_setting} - 64'd1;
			7: return {32'h0, window_setting};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 7))
			0, 1: return '0;
			6: return $urandom;
			7: return 32'd1;
			default: return LEN_W'($urandom_range(1, 'h300));
		endcase
	endfunction

	task automatic random_ops(input int count);
		int i;
		int s;
		int pick;
		for (i = 0; i < POOL_SIZE; i++) begin
			case ($urandom_range(0, 3))
				0, 1: pool_addr[i] = 64'($urandom_range(0, 255)) << 8;
				2: pool_addr[i] = 64'hFFFF_FFFF_FFFF_0000 | (64'($urandom_range(0, 255)) << 8);
				default: pool_addr[i] = {$urandom, $urandom};
			endcase
			pool_len[i] = pick_length();
		end
		for (i = 0; i < count; i++) begin
			s = $urandom_range(0, POOL_SIZE - 1);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				queue_op(FN_RESOLVE, pool_addr[s] + pick_delta(pool_len[s]), $urandom,
					HND_W'($urandom));
			end else if (pick < 75) begin
				pool_len[s] = pick_length();
				queue_op(FN_INSERT, pool_addr[s], pool_len[s], HND_W'($urandom));
			end else if (pick < 92) begin
				queue_op(FN_REMOVE, pool_addr[s] + 64'($urandom_range(0, 9) == 0), $urandom,
					HND_W'($urandom));
			end else if (pick < 96) begin
				queue_op(FN_UNUSED, {$urandom, $urandom}, $urandom, HND_W'($urandom));
			end else begin
				queue_op(FN_RESOLVE, {$urandom, $urandom}, $urandom, HND_W'($urandom));
			end
		end
	endtask

	// fill the table to capacity, push against the limit, then remove the entries it added
	task automatic fill_and_drain();
		int i;
		int fill;
		fill = DEPTH - row_count;
		for (i = 0; i < fill; i++) begin
			queue_op(FN_INSERT, FILL_BASE + FILL_STEP * i,
				($urandom_range(0, 2) == 0) ? '0 : LEN_W'($urandom_range(1, 'h80)),
				HND_W'($urandom));
			if (i % 4 == 3)
				queue_op(FN_RESOLVE, FILL_BASE + FILL_STEP * $urandom_range(0, i) +
					$urandom_range(0, 'h60), $urandom, HND_W'($urandom));
		end
		for (i = 0; i < 3; i++)
			queue_op(FN_INSERT, FILL_BASE + FILL_STEP * $urandom_range(0, fill - 1) + 8,
				$urandom, HND_W'($urandom));
		for (i = 0; i < 2; i++)
			queue_op(FN_INSERT, FILL_BASE + FILL_STEP * $urandom_range(0, fill - 1),
				$urandom_range(0, 'h30), HND_W'($urandom));
		for (i = fill - 1; i >= 0; i--) begin
			queue_op(FN_REMOVE, FILL_BASE + FILL_STEP * i, $urandom, HND_W'($urandom));
			if (i % 3 == 0)
				queue_op(FN_RESOLVE, FILL_BASE + FILL_STEP * $urandom_range(0, fill) +
					$urandom_range(0, 'h60), $urandom, HND_W'($urandom));
			if (i % 16 == 0)
				queue_op(FN_REMOVE, FILL_BASE + FILL_STEP * i + 1, $urandom,
					HND_W'($urandom));
			if (i % 20 == 0)
				queue_op(FN_UNUSED, FILL_BASE + FILL_STEP * i, $urandom, HND_W'($urandom));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_op(FN_RESOLVE, '0, '0, '0);
		queue_op(FN_REMOVE, 64'h1000, '0, '0);
		queue_op(FN_UNUSED, '1, '1, '1);
		queue_op(FN_INSERT, '0, '0, '0);
		queue_op(FN_INSERT, '1, '1, '1);
		queue_op(FN_INSERT, 64'h1_0000, 32'h100, 16'h1234);
		queue_op(FN_RESOLVE, '0, '0, '0);
		queue_op(FN_RESOLVE, 64'hFFF, '0, '0);
		queue_op(FN_RESOLVE, 64'h1000, '0, '0);
		queue_op(FN_RESOLVE, 64'h1_0000, '0, '0);
		queue_op(FN_RESOLVE, 64'h1_00FF, '0, '0);
		queue_op(FN_RESOLVE, 64'h1_0100, '0, '0);
		queue_op(FN_INSERT, 64'h2_0000, 32'h1_0000, 16'hA5A5);
		queue_op(FN_INSERT, 64'h2_0010, 32'h4, 16'h5A5A);
		queue_op(FN_RESOLVE, 64'h2_0020, '0, '0);
		queue_op(FN_RESOLVE, 64'h2_0013, '0, '0);
		queue_op(FN_INSERT, 64'h1_0000, 32'h200, 16'hBEEF);
		queue_op(FN_RESOLVE, 64'h1_01FF, '0, '0);
		queue_op(FN_RESOLVE, '1, '0, '0);
		queue_op(FN_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0);
		queue_op(FN_REMOVE, 64'h2_0010, '0, '0);
		queue_op(FN_RESOLVE, 64'h2_0020, '0, '0);
		queue_op(FN_REMOVE, 64'h2_0010, '0, '0);
		queue_op(FN_UNUSED, 64'h2_0000, 32'h5, 16'h7);
		queue_op(FN_RESOLVE, 64'h2_0000, '0, '0);

		start_phase('0, 0, 0);
		random_ops(50);
		start_phase('1, 74, 0);
		random_ops(50);
		start_phase(32'd1, 0, 74);
		fill_and_drain();
		start_phase($urandom, 21, 21);
		random_ops(50);
		start_phase(WINDOW_RESET, 21, 21);
		random_ops(50);

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
